// ===== sv/dtpb_pkg.sv =====
// Shared package for the depth-to-point back-projection block.
// Holds register indexes, reset values, controller state and command types.
// No dependencies.
package dtpb_pkg;

    // Default image limits, handed to the top level as parameter defaults.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Fixed field widths.
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int COORD_W = 32;
    localparam int PIX_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CENTER_W   = 13;
    localparam int WIDTH_CFG_W = 13;
    localparam int INV_W      = 24;
    localparam int SCALE_W    = 32;
    localparam int MUL_W      = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_HALF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE   = 3'd5;

    // Configuration reset values.
    localparam logic [WIDTH_CFG_W-1:0] RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [CENTER_W-1:0]    RST_CENTER_X_HALF = 13'd651;
    localparam logic [CENTER_W-1:0]    RST_CENTER_Y_HALF = 13'd507;
    localparam logic [INV_W-1:0]       RST_INV_FOCAL_X   = 24'd32388;
    localparam logic [INV_W-1:0]       RST_INV_FOCAL_Y   = 24'd32326;
    localparam logic [SCALE_W-1:0]     RST_DEPTH_SCALE   = 32'd4294967;

    // Controller states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_Z    = 8'b0000_0010,
        ST_MX   = 8'b0000_0100,
        ST_MY   = 8'b0000_1000,
        ST_XL   = 8'b0001_0000,
        ST_XH   = 8'b0010_0000,
        ST_YL   = 8'b0100_0000,
        ST_YH   = 8'b1000_0000
    } ctrl_state_t;

    // Operation of the shared multiplier for one cycle.
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_Z    = 3'd1,
        OP_MX   = 3'd2,
        OP_MY   = 3'd3,
        OP_XL   = 3'd4,
        OP_XH   = 3'd5,
        OP_YL   = 3'd6,
        OP_YH   = 3'd7
    } mul_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;   // Capture the accepted request and advance counters.
        mul_op_t op;        // Multiplier step to perform this cycle.
        logic    load_out;  // Move the finished point into the output register.
    } dtpb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic depth_nz;     // Depth of the offered request is nonzero.
        logic out_free;     // Output register can take a point this cycle.
    } dtpb_status_t;

endpackage

// ===== sv/dtpb_ctrl.sv =====
// Controller for the depth-to-point back-projection block.
// Sequences the shared multiplier through the steps of one point.
// Depends on dtpb_pkg.
module dtpb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dtpb_pkg::dtpb_status_t status,
    output dtpb_pkg::dtpb_cmd_t    cmd
);
    import dtpb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = accept;
                if (accept && status.depth_nz)
                begin
                    state_next = ST_Z;
                end
            end
            ST_Z:
            begin
                cmd.op     = OP_Z;
                state_next = ST_MX;
            end
            ST_MX:
            begin
                cmd.op     = OP_MX;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                cmd.op     = OP_MY;
                state_next = ST_XL;
            end
            ST_XL:
            begin
                cmd.op     = OP_XL;
                state_next = ST_XH;
            end
            ST_XH:
            begin
                cmd.op     = OP_XH;
                state_next = ST_YL;
            end
            ST_YL:
            begin
                cmd.op     = OP_YL;
                state_next = ST_YH;
            end
            ST_YH:
            begin
                // The last step waits until the output register is free.
                if (status.out_free)
                begin
                    cmd.op       = OP_YH;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/dtpb_datapath.sv =====
// Datapath for the depth-to-point back-projection block.
// Holds configuration, pixel counters, one shared 32x32 multiplier and the
// output register. Depends on dtpb_pkg.
module dtpb_datapath #(
    parameter int MAX_WIDTH  = dtpb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtpb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [dtpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtpb_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input request
    input  logic                                 start_frame,
    input  logic [dtpb_pkg::DEPTH_W-1:0]         in_depth,
    input  logic [dtpb_pkg::COLOR_W-1:0]         in_blue,
    input  logic [dtpb_pkg::COLOR_W-1:0]         in_green,
    input  logic [dtpb_pkg::COLOR_W-1:0]         in_red,
    // Control
    input  dtpb_pkg::dtpb_cmd_t                  cmd,
    output dtpb_pkg::dtpb_status_t               status,
    // Output request
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dtpb_pkg::COORD_W-1:0]  point_x,
    output logic signed [dtpb_pkg::COORD_W-1:0]  point_y,
    output logic [dtpb_pkg::COORD_W-1:0]         point_z,
    output logic [dtpb_pkg::COLOR_W-1:0]         point_red,
    output logic [dtpb_pkg::COLOR_W-1:0]         point_green,
    output logic [dtpb_pkg::COLOR_W-1:0]         point_blue,
    output logic [dtpb_pkg::PIX_W-1:0]           pixel_col,
    output logic [dtpb_pkg::PIX_W-1:0]           pixel_row
);
    import dtpb_pkg::*;

    // Counter widths and the width of the offset magnitude from the center.
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int PW0 = (CW > RW) ? CW + 1 : RW + 1;
    localparam int DW  = (PW0 > CENTER_W) ? PW0 : CENTER_W;
    // Width used to compare the column against the effective image width.
    localparam int EW  = ((CW > WIDTH_CFG_W) ? CW : WIDTH_CFG_W) + 1;
    // Offset times z, and that times the focal reciprocal.
    localparam int MW  = DW + COORD_W;
    localparam int PW  = MW + INV_W;

    // Configuration registers.
    logic [WIDTH_CFG_W-1:0] image_width_reg;
    logic [CENTER_W-1:0]    center_x_half_reg;
    logic [CENTER_W-1:0]    center_y_half_reg;
    logic [INV_W-1:0]       inv_focal_x_reg;
    logic [INV_W-1:0]       inv_focal_y_reg;
    logic [SCALE_W-1:0]     depth_scale_reg;

    // Pixel position counters.
    logic [CW-1:0] col_count_reg;
    logic [CW-1:0] col_count_next;
    logic [RW-1:0] row_count_reg;
    logic [RW-1:0] row_count_next;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [EW-1:0] width_eff;
    logic [EW-1:0] col_inc;
    logic [RW:0]   row_inc;

    // Signed offsets from the principal point.
    logic [DW:0]   dx;
    logic [DW:0]   dy;

    // Item registers.
    logic [DEPTH_W-1:0] depth_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [DW-1:0]      mag_dx_reg;
    logic [DW-1:0]      mag_dy_reg;
    logic               neg_x_reg;
    logic               neg_y_reg;
    logic [COORD_W-1:0] z_reg;
    logic [MW-1:0]      mx_reg;
    logic [MW-1:0]      my_reg;
    logic [PW-1:0]      acc_reg;
    logic [COORD_W-1:0] x_res_reg;

    // Shared multiplier.
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;
    logic [PW-1:0]      sum;
    logic [COORD_W-1:0] y_res;

    // Output register.
    logic               out_valid_reg;
    logic [COORD_W-1:0] point_x_reg;
    logic [COORD_W-1:0] point_y_reg;
    logic [COORD_W-1:0] point_z_reg;
    logic [COLOR_W-1:0] point_red_reg;
    logic [COLOR_W-1:0] point_green_reg;
    logic [COLOR_W-1:0] point_blue_reg;
    logic [PIX_W-1:0]   pixel_col_reg;
    logic [PIX_W-1:0]   pixel_row_reg;

    // Drops 25 fraction bits of the magnitude, applies the sign and saturates.
    function automatic logic [COORD_W-1:0] sat_coord(input logic [PW-1:0] full,
                                                     input logic neg);
        logic [PW-26:0]     mag;
        logic               over;
        logic [COORD_W-1:0] res;
        mag  = full[PW-1:25];
        over = |mag[PW-26:COORD_W-1];
        if (neg)
        begin
            res = over ? {1'b1, {(COORD_W-1){1'b0}}} : (~mag[COORD_W-1:0] + 1'b1);
        end
        else
        begin
            res = over ? {1'b0, {(COORD_W-1){1'b1}}} : mag[COORD_W-1:0];
        end
        return res;
    endfunction

    // Configuration write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            center_x_half_reg <= RST_CENTER_X_HALF;
            center_y_half_reg <= RST_CENTER_Y_HALF;
            inv_focal_x_reg   <= RST_INV_FOCAL_X;
            inv_focal_y_reg   <= RST_INV_FOCAL_Y;
            depth_scale_reg   <= RST_DEPTH_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[WIDTH_CFG_W-1:0];
                REG_CENTER_X_HALF: center_x_half_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y_HALF: center_y_half_reg <= cfg_data[CENTER_W-1:0];
                REG_INV_FOCAL_X:   inv_focal_x_reg   <= cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:   inv_focal_y_reg   <= cfg_data[INV_W-1:0];
                REG_DEPTH_SCALE:   depth_scale_reg   <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Position of the offered pixel and the counter advance.
    always_comb
    begin
        col_cur = start_frame ? '0 : col_count_reg;
        row_cur = start_frame ? '0 : row_count_reg;

        width_eff = EW'(image_width_reg);
        if (width_eff == '0)
        begin
            width_eff = EW'(1);
        end
        if (width_eff > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end

        col_inc = EW'(col_cur) + EW'(1);
        row_inc = (RW+1)'(row_cur) + (RW+1)'(1);
        if (col_inc >= width_eff)
        begin
            col_count_next = '0;
            row_count_next = (row_inc >= (RW+1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_count_next = col_inc[CW-1:0];
            row_count_next = row_cur;
        end

        dx = (DW+1)'({col_cur, 1'b0}) - (DW+1)'(center_x_half_reg);
        dy = (DW+1)'({row_cur, 1'b0}) - (DW+1)'(center_y_half_reg);
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cmd.load_in)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_Z:
            begin
                mul_a = MUL_W'(depth_reg);
                mul_b = MUL_W'(depth_scale_reg);
            end
            OP_MX:
            begin
                mul_a = MUL_W'(mag_dx_reg);
                mul_b = z_reg;
            end
            OP_MY:
            begin
                mul_a = MUL_W'(mag_dy_reg);
                mul_b = z_reg;
            end
            OP_XL:
            begin
                mul_a = mx_reg[MUL_W-1:0];
                mul_b = MUL_W'(inv_focal_x_reg);
            end
            OP_XH:
            begin
                mul_a = MUL_W'(mx_reg[MW-1:MUL_W]);
                mul_b = MUL_W'(inv_focal_x_reg);
            end
            OP_YL:
            begin
                mul_a = my_reg[MUL_W-1:0];
                mul_b = MUL_W'(inv_focal_y_reg);
            end
            OP_YH:
            begin
                mul_a = MUL_W'(my_reg[MW-1:MUL_W]);
                mul_b = MUL_W'(inv_focal_y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    // The upper partial product lands 32 bits above the lower one.
    assign sum   = acc_reg + {prod[PW-MUL_W-1:0], {MUL_W{1'b0}}};
    assign y_res = sat_coord(sum, neg_y_reg);

    // Item capture and multiplier result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            depth_reg  <= in_depth;
            red_reg    <= in_red;
            green_reg  <= in_green;
            blue_reg   <= in_blue;
            col_reg    <= col_cur;
            row_reg    <= row_cur;
            neg_x_reg  <= dx[DW];
            neg_y_reg  <= dy[DW];
            mag_dx_reg <= dx[DW] ? (~dx[DW-1:0] + 1'b1) : dx[DW-1:0];
            mag_dy_reg <= dy[DW] ? (~dy[DW-1:0] + 1'b1) : dy[DW-1:0];
        end
        case (cmd.op)
            OP_Z:    z_reg     <= prod[DEPTH_W+COORD_W-1:DEPTH_W];
            OP_MX:   mx_reg    <= prod[MW-1:0];
            OP_MY:   my_reg    <= prod[MW-1:0];
            OP_XL:   acc_reg   <= PW'(prod);
            OP_XH:   x_res_reg <= sat_coord(sum, neg_x_reg);
            OP_YL:   acc_reg   <= PW'(prod);
            default: ;
        endcase
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            point_x_reg     <= x_res_reg;
            point_y_reg     <= y_res;
            point_z_reg     <= z_reg;
            point_red_reg   <= red_reg;
            point_green_reg <= green_reg;
            point_blue_reg  <= blue_reg;
            pixel_col_reg   <= PIX_W'(col_reg);
            pixel_row_reg   <= PIX_W'(row_reg);
        end
    end

    assign status.depth_nz = (in_depth != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_z     = point_z_reg;
    assign point_red   = point_red_reg;
    assign point_green = point_green_reg;
    assign point_blue  = point_blue_reg;
    assign pixel_col   = pixel_col_reg;
    assign pixel_row   = pixel_row_reg;

endmodule

// ===== sv/depth_to_point_backprojection.sv =====
// A pixel with nonzero depth is run through the single shared 32x32 multiplier
// (z, two offset products, two partial products per coordinate); a new pixel is
// accepted only once the last one has finished its steps, and a zero-depth pixel
// leaves the controller idle. A waiting point stalls only the next pixel's last step.
// Reset (rst_n, asynchronous, active low) clears the counters and the controller
// and loads the default configuration.
module depth_to_point_backprojection #(
    parameter int MAX_WIDTH  = dtpb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtpb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dtpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtpb_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Pixel input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 start_frame,
    input  logic [dtpb_pkg::DEPTH_W-1:0]         in_depth,
    input  logic [dtpb_pkg::COLOR_W-1:0]         in_blue,
    input  logic [dtpb_pkg::COLOR_W-1:0]         in_green,
    input  logic [dtpb_pkg::COLOR_W-1:0]         in_red,
    // Point output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dtpb_pkg::COORD_W-1:0]  point_x,
    output logic signed [dtpb_pkg::COORD_W-1:0]  point_y,
    output logic [dtpb_pkg::COORD_W-1:0]         point_z,
    output logic [dtpb_pkg::COLOR_W-1:0]         point_red,
    output logic [dtpb_pkg::COLOR_W-1:0]         point_green,
    output logic [dtpb_pkg::COLOR_W-1:0]         point_blue,
    output logic [dtpb_pkg::PIX_W-1:0]           pixel_col,
    output logic [dtpb_pkg::PIX_W-1:0]           pixel_row
);
    import dtpb_pkg::*;

    dtpb_cmd_t    cmd;
    dtpb_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    dtpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dtpb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_frame (start_frame),
        .in_depth    (in_depth),
        .in_blue     (in_blue),
        .in_green    (in_green),
        .in_red      (in_red),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_red   (point_red),
        .point_green (point_green),
        .point_blue  (point_blue),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row)
    );

endmodule

// ===== dv/tb_depth_to_point_backprojection.sv =====
// Self-checking testbench for the depth-to-point back-projection block.
// Drives pixel, configuration and point channels with random idling and checks
// every point against a built-in predictor. Depends on dtpb_pkg and the block.
`timescale 1ns / 100ps

module tb_depth_to_point_backprojection;

    import dtpb_pkg::*;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Cycles allowed after the last point for a zero-depth pixel still in flight.
    localparam int SETTLE_CYCLES = 12;
    // Length of the long receiver hold-off.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PIXELS_PER_PHASE = 72;
    localparam int ROW_WALK_PIXELS = 64;

    // One back-projected point as it appears on the output channel.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COORD_W-1:0]        z;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic [PIX_W-1:0]          col;
        logic [PIX_W-1:0]          row;
    } point_t;

    // Predicts the points of each accepted pixel and checks the block's output.
    class point_scoreboard;
        logic [WIDTH_CFG_W-1:0] image_width;
        logic [CENTER_W-1:0]    center_x_half;
        logic [CENTER_W-1:0]    center_y_half;
        logic [INV_W-1:0]       inv_focal_x;
        logic [INV_W-1:0]       inv_focal_y;
        logic [SCALE_W-1:0]     depth_scale;
        int                     col_pos;
        int                     row_pos;
        point_t                 expected_points[$];
        int                     mismatches;
        int                     pixels_seen;
        int                     points_checked;
        int                     reg_writes;

        function new();
            image_width   = RST_IMAGE_WIDTH;
            center_x_half = RST_CENTER_X_HALF;
            center_y_half = RST_CENTER_Y_HALF;
            inv_focal_x   = RST_INV_FOCAL_X;
            inv_focal_y   = RST_INV_FOCAL_Y;
            depth_scale   = RST_DEPTH_SCALE;
            col_pos = 0;
            row_pos = 0;
            mismatches = 0;
            pixels_seen = 0;
            points_checked = 0;
            reg_writes = 0;
        endfunction

        // Registers keep only their own width of the written data.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            reg_writes++;
            case (idx)
                REG_IMAGE_WIDTH:   image_width   = val[WIDTH_CFG_W-1:0];
                REG_CENTER_X_HALF: center_x_half = val[CENTER_W-1:0];
                REG_CENTER_Y_HALF: center_y_half = val[CENTER_W-1:0];
                REG_INV_FOCAL_X:   inv_focal_x   = val[INV_W-1:0];
                REG_INV_FOCAL_Y:   inv_focal_y   = val[INV_W-1:0];
                REG_DEPTH_SCALE:   depth_scale   = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact (2*pos - center) * z * inv >> 25 on the magnitude, then saturated.
        function logic [COORD_W-1:0] project(logic [PIX_W-1:0] pos, logic [CENTER_W-1:0] center,
                                             logic [COORD_W-1:0] z, logic [INV_W-1:0] inv);
            logic signed [15:0] offset;
            logic [15:0]        offset_mag;
            logic [95:0]        product;
            logic [95:0]        mag;
            offset = $signed({3'b000, pos, 1'b0}) - $signed({3'b000, center});
            offset_mag = offset[15] ? 16'(-offset) : 16'(offset);
            product = 96'(offset_mag) * 96'(z) * 96'(inv);
            mag = product >> 25;
            if (offset[15])
            begin
                if (mag >= 96'h8000_0000)
                    return 32'h8000_0000;
                return 32'h0 - mag[31:0];
            end
            if (mag > 96'h7FFF_FFFF)
                return 32'h7FFF_FFFF;
            return mag[31:0];
        endfunction

        // Called for every accepted pixel request.
        function void note_pixel(logic sf, logic [DEPTH_W-1:0] depth, logic [COLOR_W-1:0] blue,
                                 logic [COLOR_W-1:0] green, logic [COLOR_W-1:0] red);
            point_t             pt;
            logic [COORD_W-1:0] z;
            int                 eff_width;
            pixels_seen++;
            if (sf)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (depth != 0)
            begin
                z = 32'((48'(depth) * 48'(depth_scale)) >> 16);
                pt.x = project(12'(col_pos), center_x_half, z, inv_focal_x);
                pt.y = project(12'(row_pos), center_y_half, z, inv_focal_y);
                pt.z = z;
                pt.red = red;
                pt.green = green;
                pt.blue = blue;
                pt.col = 12'(col_pos);
                pt.row = 12'(row_pos);
                expected_points.insert(expected_points.size(), pt);
            end
            // Width is clamped to 1..MAX_WIDTH; the row wraps after MAX_HEIGHT-1.
            eff_width = (image_width == 0) ? 1 :
                        ((image_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(image_width));
            if (col_pos + 1 >= eff_width)
            begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= DEF_MAX_HEIGHT) ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = col_pos + 1;
            end
        endfunction

        // Called for every accepted point; compares it with the oldest prediction.
        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected point x=%0d y=%0d z=%0d col=%0d row=%0d",
                             $time, got.x, got.y, got.z, got.col, got.row);
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.col !== want.col || got.row !== want.row)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: want x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d col=%0d row=%0d",
                             $time, want.x, want.y, want.z, want.red, want.green, want.blue,
                             want.col, want.row);
                    $display("%0t: got  x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d col=%0d row=%0d",
                             $time, got.x, got.y, got.z, got.red, got.green, got.blue,
                             got.col, got.row);
                end
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      start_frame = 1'b0;
    logic [DEPTH_W-1:0]        in_depth = '0;
    logic [COLOR_W-1:0]        in_blue = '0;
    logic [COLOR_W-1:0]        in_green = '0;
    logic [COLOR_W-1:0]        in_red = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COORD_W-1:0]        point_z;
    logic [COLOR_W-1:0]        point_red;
    logic [COLOR_W-1:0]        point_green;
    logic [COLOR_W-1:0]        point_blue;
    logic [PIX_W-1:0]          pixel_col;
    logic [PIX_W-1:0]          pixel_row;

    point_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int settings_used = 0;

    depth_to_point_backprojection DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_frame (start_frame),
        .in_depth    (in_depth),
        .in_blue     (in_blue),
        .in_green    (in_green),
        .in_red      (in_red),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_red   (point_red),
        .point_green (point_green),
        .point_blue  (point_blue),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watch both data channels; inputs are noted before outputs are checked.
    always @(posedge clk)
    begin : watch
        point_t got;
        if (in_valid && in_ready)
            sb.note_pixel(start_frame, in_depth, in_blue, in_green, in_red);
        if (out_valid && out_ready)
        begin
            got.x = point_x;
            got.y = point_y;
            got.z = point_z;
            got.red = point_red;
            got.green = point_green;
            got.blue = point_blue;
            got.col = pixel_col;
            got.row = pixel_row;
            sb.check_point(got);
        end
    end

    // Point receiver: random stall bursts and one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Fill the bits above a register's width with junk that must be dropped.
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] val, int w);
        if (w >= CFG_DATA_W)
            return val;
        return val | (CFG_DATA_W'($urandom()) << w);
    endfunction

    // One register write request; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Write a full setting, optionally preceded by writes to unused indexes.
    task automatic apply_setting(input logic [WIDTH_CFG_W-1:0] w, input logic [CENTER_W-1:0] cx,
                                 input logic [CENTER_W-1:0] cy, input logic [INV_W-1:0] fx,
                                 input logic [INV_W-1:0] fy, input logic [SCALE_W-1:0] ds,
                                 input bit with_spare);
        settings_used++;
        if (with_spare)
        begin
            write_reg(REG_SPARE_LO, $urandom());
            write_reg(REG_SPARE_HI, $urandom());
        end
        write_reg(REG_IMAGE_WIDTH, with_junk(32'(w), WIDTH_CFG_W));
        write_reg(REG_CENTER_X_HALF, with_junk(32'(cx), CENTER_W));
        write_reg(REG_CENTER_Y_HALF, with_junk(32'(cy), CENTER_W));
        write_reg(REG_INV_FOCAL_X, with_junk(32'(fx), INV_W));
        write_reg(REG_INV_FOCAL_Y, with_junk(32'(fy), INV_W));
        write_reg(REG_DEPTH_SCALE, ds);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [INV_W-1:0] pick_inv();
        case ($urandom_range(0, 3))
            0, 1:    return INV_W'($urandom_range(1000, 70000));
            2:       return INV_W'($urandom());
            default: return $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd1;
        endcase
    endfunction

    // Random setting, biased toward narrow images so rows advance often.
    task automatic random_setting();
        logic [WIDTH_CFG_W-1:0] w;
        logic [CENTER_W-1:0]    cx;
        logic [SCALE_W-1:0]     ds;
        int                     eff;
        case ($urandom_range(0, 5))
            0:       w = WIDTH_CFG_W'($urandom_range(1, 4));
            1, 2:    w = WIDTH_CFG_W'($urandom_range(5, 32));
            3:       w = WIDTH_CFG_W'($urandom_range(33, 700));
            4:       w = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
            default: w = WIDTH_CFG_W'($urandom_range(0, 8191));
        endcase
        eff = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w));
        cx = $urandom_range(0, 1) ? CENTER_W'($urandom_range(0, 8191))
                                  : CENTER_W'($urandom_range(0, 2 * eff - 1));
        case ($urandom_range(0, 3))
            0, 1:    ds = SCALE_W'($urandom_range(2000000, 70000000));
            2:       ds = $urandom();
            default: ds = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
        endcase
        apply_setting(w, cx, CENTER_W'($urandom_range(0, 8191)), pick_inv(), pick_inv(), ds,
                      $urandom_range(0, 3) == 0);
    endtask

    // Offer one pixel request, after an optional random gap, and wait for its acceptance.
    task automatic send_pixel(input logic sf, input logic [DEPTH_W-1:0] depth,
                              input logic [COLOR_W-1:0] blue, input logic [COLOR_W-1:0] green,
                              input logic [COLOR_W-1:0] red);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_frame <= sf;
        in_depth    <= depth;
        in_blue     <= blue;
        in_green    <= green;
        in_red      <= red;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        case ($urandom_range(0, 9))
            0, 1:       depth = '0;
            2, 3, 4:    depth = DEPTH_W'($urandom_range(1, 255));
            5:          depth = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
            default:    depth = DEPTH_W'($urandom());
        endcase
        send_pixel($urandom_range(0, 39) == 0, depth, COLOR_W'($urandom()),
                   COLOR_W'($urandom()), COLOR_W'($urandom()));
    endtask

    // Stop offering pixels and wait until every predicted point has come out.
    // The first edge lets the watcher note the last accepted pixel.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        logic [DEPTH_W-1:0] depth;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default setting: depth and color extremes, a skipped pixel, a restart mid-row.
        send_pixel(1'b1, 16'd1, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 16'd0, 8'd12, 8'd34, 8'd56);
        send_pixel(1'b0, 16'h5555, 8'hAA, 8'h55, 8'hAA);
        send_pixel(1'b0, 16'hAAAA, 8'h55, 8'hAA, 8'h55);
        send_pixel(1'b1, 16'd4000, 8'd1, 8'd2, 8'd3);
        wait_idle();

        // Largest gains with the center at zero: positive saturation, oversized width.
        apply_setting(13'd8191, 13'd0, 13'd0, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pixel(1'b1, 16'hFFFF, 8'd9, 8'd8, 8'd7);
        send_pixel(1'b0, 16'hFFFF, 8'd6, 8'd5, 8'd4);
        send_pixel(1'b0, 16'd1, 8'd3, 8'd2, 8'd1);
        send_pixel(1'b0, 16'd256, 8'hF0, 8'h0F, 8'hC3);
        wait_idle();

        // Center at the top and width zero: negative saturation, one pixel per row.
        apply_setting(13'd0, 13'd8191, 13'd8191, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pixel(1'b1, 16'hFFFF, 8'd1, 8'd1, 8'd1);
        send_pixel(1'b0, 16'hFFFF, 8'd2, 8'd2, 8'd2);
        send_pixel(1'b0, 16'd1, 8'd3, 8'd3, 8'd3);
        send_pixel(1'b0, 16'd0, 8'd4, 8'd4, 8'd4);
        wait_idle();

        // Zero scale and zero reciprocals, plus writes to unused indexes.
        apply_setting(13'd4096, 13'd100, 13'd100, 24'd0, 24'd0, 32'd0, 1'b1);
        send_pixel(1'b0, 16'hFFFF, 8'h80, 8'h40, 8'h20);
        send_pixel(1'b0, 16'd300, 8'h01, 8'h02, 8'h04);
        wait_idle();
        apply_setting(13'd1, 13'd0, 13'd0, 24'd1, 24'd1, 32'd1, 1'b0);
        send_pixel(1'b0, 16'hFFFF, 8'h7F, 8'hFE, 8'h3C);
        wait_idle();

        // Width one steps the row counter on every pixel; most pixels are skipped.
        apply_setting(13'd1, 13'd651, 13'd4000, RST_INV_FOCAL_X, RST_INV_FOCAL_Y,
                      RST_DEPTH_SCALE, 1'b0);
        for (int i = 0; i < ROW_WALK_PIXELS; i++)
        begin
            depth = (i % 8 == 0 || i >= ROW_WALK_PIXELS - 4) ?
                    DEPTH_W'($urandom_range(1, 65535)) : '0;
            send_pixel(i == 0, depth, COLOR_W'($urandom()), COLOR_W'($urandom()),
                       COLOR_W'($urandom()));
        end
        wait_idle();

        // Random phases; some without idling, the last one entirely without it.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on = (p != RANDOM_PHASES - 1) && (p % 4 != 2);
            random_setting();
            if (p == 3)
                long_hold_req = 1'b1;
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                if (p == 6 && i == PIXELS_PER_PHASE / 2)
                    wait_idle();
                send_random_pixel();
            end
            wait_idle();
        end

        $display("Covered %0d pixels and %0d points over %0d settings (%0d register writes),",
                 sb.pixels_seen, sb.points_checked, settings_used, sb.reg_writes);
        $display("including saturation both ways, row stepping, zero gains and long stalls.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dtpb_pkg.sv
sv/dtpb_ctrl.sv
sv/dtpb_datapath.sv
sv/depth_to_point_backprojection.sv
dv/tb_depth_to_point_backprojection.sv
